/* rtl/texture_sampler_repeat_wrap_unit_assert.svh */
// ----------------------------------------------------------------------------
// Texture sampler assertion macros
// Shared property forms for the sampler's concurrent checks. Each expects
// signals named clock and reset in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_SAMPLER_REPEAT_WRAP_UNIT_ASSERT_SVH
`define TEXTURE_SAMPLER_REPEAT_WRAP_UNIT_ASSERT_SVH

// same-cycle implication
`define TSR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tsr_pkg.sv */
// ----------------------------------------------------------------------------
// Texture sampler package
// Register codes, configuration bundle and the fixed-point blend function.
// ----------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int INT_BITS       = 17;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FILTER_BILINEAR = 3'd0,
      CSR_WIDTH_USED      = 3'd1,
      CSR_HEIGHT_USED     = 3'd2,
      CSR_SCALE_U         = 3'd3,
      CSR_SCALE_V         = 3'd4,
      CSR_OFFSET_U        = 3'd5,
      CSR_OFFSET_V        = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic               filter_bilinear;
      logic [8:0]         width_used;
      logic [8:0]         height_used;
      logic [10:0]        scale_u;
      logic [10:0]        scale_v;
      logic signed [31:0] offset_u;
      logic signed [31:0] offset_v;
   } cfg_type;

   // (a*(1-f) + b*f) with round half up, f in 1/65536 units
   function automatic logic [31:0] lerp(input logic [31:0] a, input logic [31:0] b,
                                        input logic [15:0] f);
      logic [16:0] wa;
      logic [48:0] sum;
      wa  = 17'h10000 - {1'b0, f};
      sum = 49'(a) * 49'(wa) + 49'(b) * 49'(f) + 49'(32768);
      return sum[47:16];
   endfunction

endpackage

`default_nettype wire

/* rtl/tsr_fifo.sv */
// ----------------------------------------------------------------------------
// Texture sampler queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

/* rtl/tsr_front.sv */
// ----------------------------------------------------------------------------
// Texture sampler front end
// Accepts words, scales and offsets u,v, splits floor and fraction and wraps
// the texel index with a one-bit-per-stage remainder pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tsr_front #(
   parameter int MAX_DIM = 256,
   localparam int AW = $clog2(MAX_DIM),
   localparam int QW = 2 + 4 * AW + 5 * 16
) (
   input  logic                clock,
   input  logic                reset,
   input  tsr_pkg::cfg_type    cfg,
   input  logic                in_push,
   output logic                in_full,
   input  logic                in_mode,
   input  logic [7:0]          in_col,
   input  logic [7:0]          in_row,
   input  logic [15:0]         in_red,
   input  logic [15:0]         in_green,
   input  logic [15:0]         in_blue,
   input  logic signed [20:0]  in_u,
   input  logic signed [20:0]  in_v,
   output logic                out_push,
   input  logic                out_full,
   output logic [QW-1:0]       out_word
);

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int IB = tsr_pkg::INT_BITS;

   typedef struct packed {
      logic          smp;
      logic [7:0]    col;
      logic [7:0]    row;
      logic [15:0]   red;
      logic [15:0]   green;
      logic [15:0]   blue;
      logic [15:0]   fu;
      logic [15:0]   fv;
      logic          nu;
      logic          nv;
      logic [IB-1:0] mu;
      logic [IB-1:0] mv;
      logic [DW-1:0] ru;
      logic [DW-1:0] rv;
   } mst_type;

   typedef struct packed {
      logic          smp;
      logic          wok;
      logic [AW-1:0] x;
      logic [AW-1:0] y;
      logic [AW-1:0] x1;
      logic [AW-1:0] y1;
      logic [15:0]   fu;
      logic [15:0]   fv;
      logic [15:0]   red;
      logic [15:0]   green;
      logic [15:0]   blue;
   } item_type;

   function automatic logic [DW-1:0] clamp_dim(input logic [8:0] d);
      if (d == '0) begin
         return DW'(1);
      end else if (32'(d) > 32'(MAX_DIM)) begin
         return DW'(MAX_DIM);
      end
      return DW'(d);
   endfunction

   function automatic logic [DW-1:0] mod_step(input logic [DW-1:0] r, input logic b,
                                              input logic [DW-1:0] d);
      logic [DW:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         return DW'(t - {1'b0, d});
      end
      return DW'(t);
   endfunction

   logic [DW-1:0] wc, hc;
   logic          en;

   logic               v1_ff, v2_ff, f_v_ff, g_v_ff;
   mst_type            m1_ff, m1_in, m2_ff, m2_in, f_ff, f_in;
   logic signed [31:0] pu1_ff, pv1_ff, pu1_in, pv1_in;
   logic [IB-1:0]      ipu2_ff, ipv2_ff, ipu2_in, ipv2_in;
   logic signed [32:0] pu_full, pv_full, pos_u, pos_v;
   logic               vld_ff [IB+1];
   mst_type            st_ff [IB+1];
   mst_type            st_in [IB+1];
   item_type           g_ff, g_in;
   logic [DW-1:0]      xs, ys;

   assign wc       = clamp_dim(cfg.width_used);
   assign hc       = clamp_dim(cfg.height_used);
   assign en       = !(g_v_ff && out_full);
   assign in_full  = !en;
   assign out_push = g_v_ff && !out_full;
   assign out_word = g_ff;

   always_comb begin
      pu_full      = 33'(in_u) * $signed({22'd0, cfg.scale_u});
      pv_full      = 33'(in_v) * $signed({22'd0, cfg.scale_v});
      pu1_in       = $signed(pu_full[31:0]);
      pv1_in       = $signed(pv_full[31:0]);
      m1_in        = '0;
      m1_in.smp    = in_mode;
      m1_in.col    = in_col;
      m1_in.row    = in_row;
      m1_in.red    = in_red;
      m1_in.green  = in_green;
      m1_in.blue   = in_blue;

      pos_u        = 33'(pu1_ff) + 33'(cfg.offset_u);
      pos_v        = 33'(pv1_ff) + 33'(cfg.offset_v);
      m2_in        = m1_ff;
      m2_in.fu     = pos_u[15:0];
      m2_in.fv     = pos_v[15:0];
      ipu2_in      = pos_u[32:16];
      ipv2_in      = pos_v[32:16];

      st_in[0]     = m2_ff;
      st_in[0].nu  = ipu2_ff[IB-1];
      st_in[0].nv  = ipv2_ff[IB-1];
      st_in[0].mu  = ipu2_ff[IB-1] ? (~ipu2_ff + 1'b1) : ipu2_ff;
      st_in[0].mv  = ipv2_ff[IB-1] ? (~ipv2_ff + 1'b1) : ipv2_ff;
      st_in[0].ru  = '0;
      st_in[0].rv  = '0;
      for (int j = 0; j < IB; j++) begin
         st_in[j+1]    = st_ff[j];
         st_in[j+1].ru = mod_step(st_ff[j].ru, st_ff[j].mu[IB-1-j], wc);
         st_in[j+1].rv = mod_step(st_ff[j].rv, st_ff[j].mv[IB-1-j], hc);
      end

      f_in    = st_ff[IB];
      f_in.ru = (st_ff[IB].nu && st_ff[IB].ru != '0) ? wc - st_ff[IB].ru : st_ff[IB].ru;
      f_in.rv = (st_ff[IB].nv && st_ff[IB].rv != '0) ? hc - st_ff[IB].rv : st_ff[IB].rv;

      xs       = f_ff.ru + DW'(1);
      ys       = f_ff.rv + DW'(1);
      g_in.smp   = f_ff.smp;
      g_in.wok   = (32'(f_ff.col) < 32'(MAX_DIM)) && (32'(f_ff.row) < 32'(MAX_DIM));
      g_in.x     = f_ff.smp ? AW'(f_ff.ru) : AW'(f_ff.col);
      g_in.y     = f_ff.smp ? AW'(f_ff.rv) : AW'(f_ff.row);
      g_in.x1    = (xs == wc) ? '0 : AW'(xs);
      g_in.y1    = (ys == hc) ? '0 : AW'(ys);
      g_in.fu    = f_ff.fu;
      g_in.fv    = f_ff.fv;
      g_in.red   = f_ff.red;
      g_in.green = f_ff.green;
      g_in.blue  = f_ff.blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         for (int j = 0; j <= IB; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else if (en) begin
         v1_ff     <= in_push;
         v2_ff     <= v1_ff;
         vld_ff[0] <= v2_ff;
         for (int j = 0; j < IB; j++) begin
            vld_ff[j+1] <= vld_ff[j];
         end
         f_v_ff <= vld_ff[IB];
         g_v_ff <= f_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff   <= m1_in;
         pu1_ff  <= pu1_in;
         pv1_ff  <= pv1_in;
         m2_ff   <= m2_in;
         ipu2_ff <= ipu2_in;
         ipv2_ff <= ipv2_in;
         for (int j = 0; j <= IB; j++) begin
            st_ff[j] <= st_in[j];
         end
         f_ff <= f_in;
         g_ff <= g_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tsr_back.sv */
// ----------------------------------------------------------------------------
// Texture sampler back end
// Single-port texel memory, access sequencer, bilinear blend stages and the
// result queue with credit tracking.
// ----------------------------------------------------------------------------
`default_nettype none

`include "texture_sampler_repeat_wrap_unit_assert.svh"

module tsr_back #(
   parameter int MAX_DIM = 256,
   parameter int CHANNEL_BITS = 16,
   localparam int AW = $clog2(MAX_DIM),
   localparam int QW = 2 + 4 * AW + 5 * 16
) (
   input  logic             clock,
   input  logic             reset,
   input  tsr_pkg::cfg_type cfg,
   input  logic             in_empty,
   output logic             in_pop,
   input  logic [QW-1:0]    in_word,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [15:0]      rsp_red,
   output logic [15:0]      rsp_green,
   output logic [15:0]      rsp_blue
);

   localparam int CB        = CHANNEL_BITS;
   localparam int TW        = 3 * CB;
   localparam int MW        = 2 * AW;
   localparam int OUT_DEPTH = 8;
   localparam int OCW       = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic          smp;
      logic          wok;
      logic [AW-1:0] x;
      logic [AW-1:0] y;
      logic [AW-1:0] x1;
      logic [AW-1:0] y1;
      logic [15:0]   fu;
      logic [15:0]   fv;
      logic [15:0]   red;
      logic [15:0]   green;
      logic [15:0]   blue;
   } item_type;

   logic [TW-1:0] mem [1 << MW];

   item_type       head, cur_ff, cur_in;
   logic           busy_ff, busy_in;
   logic [1:0]     step_ff, step_in, last_step;
   logic           is_last, take;
   logic [OCW-1:0] outst_ff, outst_in;
   logic           we, re;
   logic [MW-1:0]  addr;
   logic [TW-1:0]  wdata, rdata_ff;

   logic           rd_v_ff, rd_last_ff;
   logic [1:0]     rd_k_ff;
   logic [15:0]    l_fu_ff, l_fv_ff, cap_fu_ff, cap_fv_ff, a_fv_ff;
   logic           l_near_ff, cap_near_ff, a_near_ff;
   logic           cap_go_ff, a_go_ff;
   logic [TW-1:0]  tex_ff [4];
   logic [TW-1:0]  top_ff, bot_ff, top_in, bot_in;
   logic [47:0]    res;
   logic           out_push, out_full, rsp_take;
   logic [47:0]    out_rdata;

   assign head      = item_type'(in_word);
   assign last_step = (cur_ff.smp && cfg.filter_bilinear) ? 2'd3 : 2'd0;
   assign is_last   = (step_ff == last_step);
   assign take      = (!busy_ff || is_last) && !in_empty &&
                      (!head.smp || outst_ff < OCW'(OUT_DEPTH));
   assign in_pop    = take;
   assign rsp_take  = rsp_pop && !rsp_empty;
   assign we        = busy_ff && !cur_ff.smp && cur_ff.wok;
   assign re        = busy_ff && cur_ff.smp;
   assign wdata     = {CB'(cur_ff.blue), CB'(cur_ff.green), CB'(cur_ff.red)};

   always_comb begin
      case (step_ff)
         2'd0:    addr = {cur_ff.y, cur_ff.x};
         2'd1:    addr = {cur_ff.y, cur_ff.x1};
         2'd2:    addr = {cur_ff.y1, cur_ff.x};
         2'd3:    addr = {cur_ff.y1, cur_ff.x1};
         default: addr = {cur_ff.y, cur_ff.x};
      endcase
   end

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff && !is_last;
      step_in = step_ff + 2'd1;
      if (take) begin
         cur_in  = head;
         busy_in = 1'b1;
         step_in = 2'd0;
      end
      outst_in = outst_ff + OCW'(take && head.smp) - OCW'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         step_ff   <= 2'd0;
         outst_ff  <= '0;
         rd_v_ff   <= 1'b0;
         cap_go_ff <= 1'b0;
         a_go_ff   <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         step_ff   <= step_in;
         outst_ff  <= outst_in;
         rd_v_ff   <= re;
         cap_go_ff <= rd_v_ff && rd_last_ff;
         a_go_ff   <= cap_go_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      rd_k_ff    <= step_ff;
      rd_last_ff <= is_last;
      if (re && is_last) begin
         l_fu_ff   <= cur_ff.fu;
         l_fv_ff   <= cur_ff.fv;
         l_near_ff <= !cfg.filter_bilinear;
      end
      if (rd_v_ff) begin
         tex_ff[rd_k_ff] <= rdata_ff;
      end
      cap_fu_ff   <= l_fu_ff;
      cap_fv_ff   <= l_fv_ff;
      cap_near_ff <= l_near_ff;
      top_ff      <= top_in;
      bot_ff      <= bot_in;
      a_fv_ff     <= cap_fv_ff;
      a_near_ff   <= cap_near_ff;
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         top_in[ch*CB +: CB] = cap_near_ff ? tex_ff[0][ch*CB +: CB] :
            CB'(tsr_pkg::lerp(32'(tex_ff[0][ch*CB +: CB]), 32'(tex_ff[1][ch*CB +: CB]),
                              cap_fu_ff));
         bot_in[ch*CB +: CB] =
            CB'(tsr_pkg::lerp(32'(tex_ff[2][ch*CB +: CB]), 32'(tex_ff[3][ch*CB +: CB]),
                              cap_fu_ff));
         res[ch*16 +: 16] = a_near_ff ? 16'(top_ff[ch*CB +: CB]) :
            16'(tsr_pkg::lerp(32'(top_ff[ch*CB +: CB]), 32'(bot_ff[ch*CB +: CB]), a_fv_ff));
      end
   end

   assign out_push = a_go_ff;

   tsr_fifo #(
      .WIDTH (48),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (res),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign rsp_red   = out_rdata[15:0];
   assign rsp_green = out_rdata[31:16];
   assign rsp_blue  = out_rdata[47:32];

   `TSR_ASSERT_SAME(a_rsp_no_overflow, out_push, !out_full, "result queue overflow")
   `TSR_ASSERT_SAME(a_rsp_has_credit, !rsp_empty, outst_ff != '0, "result without credit")
   `TSR_ASSERT_SAME(a_no_take_midway, busy_ff && !is_last, !in_pop, "item taken mid access")

endmodule

`default_nettype wire

/* rtl/texture_sampler_repeat_wrap_unit.sv */
// ----------------------------------------------------------------------------
// Texture sampler with repeat wrap and nearest or bilinear filtering
// Bilinear samples make four reads on the single texel port; nearest samples
// and texel writes make one access each. The sequencer takes the next item
// on the last access of the current one, if a sample has result-queue credit.
// Reset clears control state and loads configuration defaults; texel memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_sampler_repeat_wrap_unit #(
   parameter int MAX_DIM = 256,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_mode,
   input  logic [7:0]                           req_texel_col,
   input  logic [7:0]                           req_texel_row,
   input  logic [15:0]                          req_write_red,
   input  logic [15:0]                          req_write_green,
   input  logic [15:0]                          req_write_blue,
   input  logic signed [20:0]                   req_coord_u,
   input  logic signed [20:0]                   req_coord_v,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [15:0]                          rsp_red,
   output logic [15:0]                          rsp_green,
   output logic [15:0]                          rsp_blue,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tsr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tsr_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int AW = $clog2(MAX_DIM);
   localparam int QW = 2 + 4 * AW + 5 * 16;

   tsr_pkg::cfg_type cfg_ff;
   logic             mid_push, mid_full, mid_pop, mid_empty;
   logic [QW-1:0]    mid_wdata, mid_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_bilinear <= 1'b1;
         cfg_ff.width_used      <= 9'd256;
         cfg_ff.height_used     <= 9'd256;
         cfg_ff.scale_u         <= 11'd256;
         cfg_ff.scale_v         <= 11'd256;
         cfg_ff.offset_u        <= '0;
         cfg_ff.offset_v        <= '0;
      end else if (csr_valid && csr_ready) begin
         case (tsr_pkg::csr_index_type'(csr_index))
            tsr_pkg::CSR_FILTER_BILINEAR: cfg_ff.filter_bilinear <= csr_data[0];
            tsr_pkg::CSR_WIDTH_USED:      cfg_ff.width_used      <= csr_data[8:0];
            tsr_pkg::CSR_HEIGHT_USED:     cfg_ff.height_used     <= csr_data[8:0];
            tsr_pkg::CSR_SCALE_U:         cfg_ff.scale_u         <= csr_data[10:0];
            tsr_pkg::CSR_SCALE_V:         cfg_ff.scale_v         <= csr_data[10:0];
            tsr_pkg::CSR_OFFSET_U:        cfg_ff.offset_u        <= $signed(csr_data);
            tsr_pkg::CSR_OFFSET_V:        cfg_ff.offset_v        <= $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   tsr_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_push  (req_push),
      .in_full  (req_full),
      .in_mode  (req_mode),
      .in_col   (req_texel_col),
      .in_row   (req_texel_row),
      .in_red   (req_write_red),
      .in_green (req_write_green),
      .in_blue  (req_write_blue),
      .in_u     (req_coord_u),
      .in_v     (req_coord_v),
      .out_push (mid_push),
      .out_full (mid_full),
      .out_word (mid_wdata)
   );

   tsr_fifo #(
      .WIDTH (QW),
      .DEPTH (4)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   tsr_back #(
      .MAX_DIM      (MAX_DIM),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_empty  (mid_empty),
      .in_pop    (mid_pop),
      .in_word   (mid_rdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Texture sampler testbench
// Loads texels, samples them through nearest and bilinear filtering under a
// series of wrap, scale and offset settings, and checks every color word
// against a cycle-free predictor kept alongside a shadow copy of the texture.
// Samples only touch texels the shadow copy has seen written.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int  LIMIT       = 600000;
   localparam int  DRAIN       = 40;
   localparam int  PHASE_WORDS = 80;
   localparam bit  WORD_WRITE  = 1'b0;
   localparam bit  WORD_SAMPLE = 1'b1;
   localparam logic [tsr_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      bit                 mode;
      logic [7:0]         col;
      logic [7:0]         row;
      logic [15:0]        r, g, b;
      logic signed [20:0] u, v;
      bit                 known;
      logic [47:0]        color;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_push = 1'b0;
   logic                                req_full;
   logic                                req_mode = 1'b0;
   logic [7:0]                          req_texel_col = '0;
   logic [7:0]                          req_texel_row = '0;
   logic [15:0]                         req_write_red = '0;
   logic [15:0]                         req_write_green = '0;
   logic [15:0]                         req_write_blue = '0;
   logic signed [20:0]                  req_coord_u = '0;
   logic signed [20:0]                  req_coord_v = '0;
   logic                                rsp_empty;
   logic                                rsp_pop = 1'b0;
   logic [15:0]                         rsp_red, rsp_green, rsp_blue;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [tsr_pkg::CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [tsr_pkg::CSR_DATA_BITS-1:0]   csr_data = '0;

   tsr_pkg::cfg_type cfg;
   logic [47:0] shadow_texels [65536];
   bit          texel_written [65536];
   logic [47:0] colors_due [$];
   int          errors = 0;
   int          cycles = 0;
   int          samples_sent = 0;
   int          writes_sent = 0;
   int          colors_seen = 0;
   int          stall_req = 0;
   int          stall_done = 0;
   int          stall_left = 0;
   bit          calm = 1'b0;

   texture_sampler_repeat_wrap_unit uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // position split, repeat wrap and neighbor indexes under the current settings
   function automatic void locate(input logic signed [20:0] u, input logic signed [20:0] v,
                                  output int x, output int y, output int x1,
                                  output int y1, output longint fu, output longint fv);
      longint pu, pv, w, h, m;
      w  = (cfg.width_used == 0) ? 1 : (cfg.width_used > 256) ? 256 : cfg.width_used;
      h  = (cfg.height_used == 0) ? 1 : (cfg.height_used > 256) ? 256 : cfg.height_used;
      pu = longint'(u) * longint'(cfg.scale_u) + longint'(cfg.offset_u);
      pv = longint'(v) * longint'(cfg.scale_v) + longint'(cfg.offset_v);
      fu = pu & 65535;
      fv = pv & 65535;
      m  = (pu >>> 16) % w;
      if (m < 0) m += w;
      x  = int'(m);
      m  = (pv >>> 16) % h;
      if (m < 0) m += h;
      y  = int'(m);
      x1 = (x + 1 == w) ? 0 : x + 1;
      y1 = (y + 1 == h) ? 0 : y + 1;
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint f);
      return (a * (65536 - f) + b * f + 32768) >>> 16;
   endfunction

   function automatic logic [47:0] filtered_color(input logic signed [20:0] u,
                                                  input logic signed [20:0] v);
      int          x, y, x1, y1;
      longint      fu, fv, top, bot;
      logic [47:0] t00, t10, t01, t11, color;
      locate(u, v, x, y, x1, y1, fu, fv);
      t00 = shadow_texels[y * 256 + x];
      t10 = shadow_texels[y * 256 + x1];
      t01 = shadow_texels[y1 * 256 + x];
      t11 = shadow_texels[y1 * 256 + x1];
      if (!cfg.filter_bilinear) return t00;
      for (int ch = 0; ch < 3; ch++) begin
         top = blend(t00[ch*16 +: 16], t10[ch*16 +: 16], fu);
         bot = blend(t01[ch*16 +: 16], t11[ch*16 +: 16], fu);
         color[ch*16 +: 16] = 16'(blend(top, bot, fv));
      end
      return color;
   endfunction

   task automatic send_word(input stim_row_type w);
      if (!calm)
         while ($urandom_range(99) < 22) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
      req_push        <= 1'b1;
      req_mode        <= w.mode;
      req_texel_col   <= w.col;
      req_texel_row   <= w.row;
      req_write_red   <= w.r;
      req_write_green <= w.g;
      req_write_blue  <= w.b;
      req_coord_u     <= w.u;
      req_coord_v     <= w.v;
      do @(posedge clock); while (req_full);
      if (w.mode == WORD_WRITE) begin
         shadow_texels[{w.row, w.col}] = {w.b, w.g, w.r};
         texel_written[{w.row, w.col}] = 1'b1;
         writes_sent++;
      end else begin
         colors_due.push_back(w.known ? w.color : filtered_color(w.u, w.v));
         samples_sent++;
      end
   endtask

   function automatic stim_row_type random_row(input bit mode);
      stim_row_type w;
      w.mode  = mode;
      w.col   = 8'($urandom);
      w.row   = 8'($urandom);
      w.r     = 16'($urandom);
      w.g     = 16'($urandom);
      w.b     = 16'($urandom);
      w.u     = 21'($urandom);
      w.v     = 21'($urandom);
      w.known = 1'b0;
      w.color = '0;
      return w;
   endfunction

   task automatic fill_texel(input int col, input int row);
      stim_row_type w;
      if (!texel_written[row * 256 + col]) begin
         w     = random_row(WORD_WRITE);
         w.col = 8'(col);
         w.row = 8'(row);
         send_word(w);
      end
   endtask

   // write any texel the sample would read before sending it
   task automatic sample_word(input stim_row_type w);
      int     x, y, x1, y1;
      longint fu, fv;
      locate(w.u, w.v, x, y, x1, y1, fu, fv);
      fill_texel(x, y);
      if (cfg.filter_bilinear) begin
         fill_texel(x1, y);
         fill_texel(x, y1);
         fill_texel(x1, y1);
      end
      send_word(w);
   endtask

   task automatic write_reg(input logic [tsr_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tsr_pkg::CSR_FILTER_BILINEAR: cfg.filter_bilinear = data[0];
         tsr_pkg::CSR_WIDTH_USED:      cfg.width_used = data[8:0];
         tsr_pkg::CSR_HEIGHT_USED:     cfg.height_used = data[8:0];
         tsr_pkg::CSR_SCALE_U:         cfg.scale_u = data[10:0];
         tsr_pkg::CSR_SCALE_V:         cfg.scale_v = data[10:0];
         tsr_pkg::CSR_OFFSET_U:        cfg.offset_u = data;
         tsr_pkg::CSR_OFFSET_V:        cfg.offset_v = data;
         default: ;
      endcase
   endtask

   task automatic configure(input bit filt, input int w, input int h, input int su,
                            input int sv, input logic [31:0] ou, input logic [31:0] ov);
      req_push <= 1'b0;
      while (colors_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      write_reg(tsr_pkg::CSR_FILTER_BILINEAR, 32'(filt));
      write_reg(tsr_pkg::CSR_WIDTH_USED, 32'(w));
      write_reg(tsr_pkg::CSR_HEIGHT_USED, 32'(h));
      write_reg(tsr_pkg::CSR_SCALE_U, 32'(su));
      write_reg(tsr_pkg::CSR_SCALE_V, 32'(sv));
      write_reg(tsr_pkg::CSR_OFFSET_U, ou);
      write_reg(tsr_pkg::CSR_OFFSET_V, ov);
      write_reg(CSR_SPARE, 32'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_words(input int count);
      stim_row_type w;
      int           wu, hv;
      wu = (cfg.width_used == 0) ? 1 : (cfg.width_used > 256) ? 256 : cfg.width_used;
      hv = (cfg.height_used == 0) ? 1 : (cfg.height_used > 256) ? 256 : cfg.height_used;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 35) begin
            w = random_row(WORD_WRITE);
            if ($urandom_range(3) != 0) begin
               w.col = 8'($urandom_range(wu - 1));
               w.row = 8'($urandom_range(hv - 1));
            end
            send_word(w);
         end else begin
            w = random_row(WORD_SAMPLE);
            if ($urandom_range(4) == 0) begin
               w.u = 21'($signed($urandom_range(8191)) - 4096);
               w.v = 21'($signed($urandom_range(8191)) - 4096);
            end
            sample_word(w);
         end
      end
   endtask

   // results: random pops, one long hold-off on request
   always @(posedge clock) begin
      logic [47:0] due;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            colors_seen++;
            if (colors_due.size() == 0) begin
               $error("color word with none expected: %h %h %h", rsp_red, rsp_green,
                      rsp_blue);
               errors++;
            end else begin
               due = colors_due.pop_front();
               if (rsp_red !== due[15:0]) begin
                  $error("red: expected %h, got %h", due[15:0], rsp_red);
                  errors++;
               end
               if (rsp_green !== due[31:16]) begin
                  $error("green: expected %h, got %h", due[31:16], rsp_green);
                  errors++;
               end
               if (rsp_blue !== due[47:32]) begin
                  $error("blue: expected %h, got %h", due[47:32], rsp_blue);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (stall_req != stall_done) begin
            stall_done++;
            stall_left = 300;
            rsp_pop <= 1'b0;
         end else
            rsp_pop <= calm || ($urandom_range(99) >= 22);
      end
   end

   stim_row_type directed [15] = '{
      '{WORD_WRITE,  8'd0,   8'd0,   16'hFFFF, 16'h0000, 16'h8001, 21'sd0, 21'sd0, 0, 48'h0},
      '{WORD_WRITE,  8'd1,   8'd0,   16'h0000, 16'hFFFF, 16'h0000, 21'sd0, 21'sd0, 0, 48'h0},
      '{WORD_WRITE,  8'd0,   8'd1,   16'h1234, 16'h5678, 16'h9ABC, 21'sd0, 21'sd0, 0, 48'h0},
      '{WORD_WRITE,  8'd1,   8'd1,   16'hFFFF, 16'hFFFF, 16'hFFFF, 21'sd0, 21'sd0, 0, 48'h0},
      '{WORD_SAMPLE, 8'd0,   8'd0,   16'h0,    16'h0,    16'h0,    21'sd0, 21'sd0, 1,
        {16'h8001, 16'h0000, 16'hFFFF}},
      '{WORD_SAMPLE, 8'd0,   8'd0,   16'h0,    16'h0,    16'h0,    21'sd128, 21'sd0, 0, 48'h0},
      '{WORD_SAMPLE, 8'd0,   8'd0,   16'h0,    16'h0,    16'h0,    21'sd128, 21'sd128, 0,
        48'h0},
      '{WORD_WRITE,  8'd255, 8'd255, 16'hABCD, 16'h0001, 16'hFFFE, 21'sd0, 21'sd0, 0, 48'h0},
      '{WORD_WRITE,  8'd0,   8'd255, 16'h0000, 16'h0000, 16'h0000, 21'sd0, 21'sd0, 0, 48'h0},
      '{WORD_WRITE,  8'd255, 8'd0,   16'h0000, 16'h0000, 16'h0000, 21'sd0, 21'sd0, 0, 48'h0},
      '{WORD_WRITE,  8'd1,   8'd255, 16'h0000, 16'h0000, 16'h0000, 21'sd0, 21'sd0, 0, 48'h0},
      '{WORD_SAMPLE, 8'd0,   8'd0,   16'h0,    16'h0,    16'h0,    -21'sd256, -21'sd256, 1,
        {16'hFFFE, 16'h0001, 16'hABCD}},
      '{WORD_SAMPLE, 8'd0,   8'd0,   16'h0,    16'h0,    16'h0,    -21'sd1048576,
        21'sd1048575, 0, 48'h0},
      '{WORD_SAMPLE, 8'd0,   8'd0,   16'h0,    16'h0,    16'h0,    21'sd1048575,
        -21'sd1048576, 0, 48'h0},
      '{WORD_WRITE,  8'd128, 8'd64,  16'h5555, 16'hAAAA, 16'h7FFF, 21'sd0, 21'sd0, 0, 48'h0}
   };

   initial begin
      cfg = '{1'b1, 9'd256, 9'd256, 11'd256, 11'd256, 32'sd0, 32'sd0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].mode == WORD_SAMPLE) sample_word(directed[i]);
         else send_word(directed[i]);
      end

      configure(1'b1, 8, 8, 256, 256, 32'h0, 32'h0);
      random_words(PHASE_WORDS);
      configure(1'b0, 8, 4, 1, 1, 32'h0000_8000, -32'sh0003_0000);
      stall_req++;
      random_words(PHASE_WORDS);
      configure(1'b1, 1, 1, 1024, 1024, 32'h7FFF_FFFF, 32'h8000_0000);
      random_words(PHASE_WORDS);
      configure(1'b1, 256, 256, 2047, 0, 32'h0001_2345, -32'sd5);
      calm = 1'b1;
      random_words(PHASE_WORDS);
      calm = 1'b0;
      configure(1'b0, 0, 300, 3, 7, $urandom, $urandom);
      random_words(PHASE_WORDS);
      configure(1'b1, 3, 5, 17, 200, $urandom, $urandom);
      random_words(PHASE_WORDS);
      configure(1'b1, 2, 256, 1024, 1, $urandom, $urandom);
      random_words(PHASE_WORDS);
      configure(1'b0, 256, 1, 511, 1024, $urandom, $urandom);
      random_words(PHASE_WORDS);
      configure(1'b1, 511, 7, 5, 9, $urandom, $urandom);
      random_words(PHASE_WORDS);

      req_push <= 1'b0;
      while (colors_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("covered %0d texel writes and %0d samples over nine register settings",
               writes_sent, samples_sent);
      $display("%0d color words checked, %0d mismatches", colors_seen, errors);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/tsr_pkg.sv
rtl/tsr_fifo.sv
rtl/tsr_front.sv
rtl/tsr_back.sv
rtl/texture_sampler_repeat_wrap_unit.sv
tb/sv/testbench.sv
